// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the tone event sequencer RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TES_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define TES_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/tes_pkg.sv =====
// Types and constants of the tone event sequencer.
// No dependencies; imported by the interfaces and all RTL modules.
package tes_pkg;

	localparam int ACTION_W = 3;
	localparam int REQ_W    = 15;
	localparam int DIV_W    = 16;
	localparam int DUR_W    = 16;
	localparam int STATUS_W = 2;
	localparam int LEVEL_W  = 6;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH  = 3'd0,
		ACT_START = 3'd1,
		ACT_STOP  = 3'd2,
		ACT_EXIT  = 3'd3,
		ACT_TICK  = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_BUSY = 2'd2
	} status_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_PLAYING
	} seq_state_t;

	// Controller to datapath
	typedef struct packed {
		logic    accept;
		logic    push;
		logic    pop;
		logic    play;
		logic    halt;
		logic    claim;
		logic    tick;
		logic    timer_off;
		status_t status;
	} tes_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic owner_match;
		logic timer_on;
		logic tick_last;
		logic head_stop;
	} tes_stat_t;

endpackage

// ===== rtl/tes_channel_if.sv =====
// Valid/ready channels: one carries a sequencer item, the other its result.
// Depends on tes_pkg for field widths.
interface tes_item_if;
	import tes_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [REQ_W-1:0]    requester_id;
	logic [DIV_W-1:0]    tone_divisor;
	logic [DUR_W-1:0]    duration_ticks;
	logic                tone_flag;
	logic                stop_flag;

	modport source (output valid, action, requester_id, tone_divisor, duration_ticks,
		tone_flag, stop_flag, input ready);
	modport sink (input valid, action, requester_id, tone_divisor, duration_ticks,
		tone_flag, stop_flag, output ready);
endinterface

interface tes_result_if;
	import tes_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                gate_on;
	logic [DIV_W-1:0]    divisor_out;
	logic                divisor_load;
	logic                playing;
	logic [LEVEL_W-1:0]  queue_level;

	modport source (output valid, status, gate_on, divisor_out, divisor_load, playing,
		queue_level, input ready);
	modport sink (input valid, status, gate_on, divisor_out, divisor_load, playing,
		queue_level, output ready);
endinterface

// ===== rtl/tes_controller.sv =====
// Sequencer controller: decodes each transaction into datapath commands,
// tracks playback state and owns the result valid flag. Uses tes_pkg.
`include "assert_macros.svh"

module tes_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [tes_pkg::ACTION_W-1:0] action,
	output logic                         in_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  tes_pkg::tes_stat_t           stat,
	output tes_pkg::tes_cmd_t            cmd,
	output logic                         playing
);
	import tes_pkg::*;

	seq_state_t state_q, state_d;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign playing   = (state_q == SEQ_PLAYING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		if (cmd.halt) begin
			state_d = SEQ_IDLE;
		end else if (cmd.claim) begin
			state_d = SEQ_PLAYING;
		end
	end

	always_comb begin
		logic do_adv;
		do_adv     = 1'b0;
		cmd        = '0;
		cmd.status = STAT_OK;
		cmd.accept = accept;
		if (accept) begin
			case (action)
				ACT_PUSH: begin
					if (playing && !stat.owner_match) begin
						cmd.status = STAT_BUSY;
					end else if (stat.full) begin
						cmd.status = STAT_FULL;
					end else begin
						cmd.push = 1'b1;
					end
				end
				ACT_START: begin
					if (!playing) begin
						cmd.claim = 1'b1;
						do_adv    = 1'b1;
					end
				end
				ACT_STOP: cmd.halt = 1'b1;
				ACT_EXIT: cmd.halt = stat.owner_match;
				ACT_TICK: begin
					if (stat.timer_on) begin
						cmd.tick = 1'b1;
						if (stat.tick_last) begin
							cmd.timer_off = 1'b1;
							do_adv        = playing;
						end
					end
				end
				default: ;
			endcase
		end
		// next event: empty queue or stop-flagged head ends playback
		if (do_adv) begin
			if (stat.empty || stat.head_stop) begin
				cmd.halt = 1'b1;
			end else begin
				cmd.pop  = 1'b1;
				cmd.play = 1'b1;
			end
		end
	end

	`TES_ASSERT_IMPLY(a_idle_no_timer, clk, arst_n, state_q == SEQ_IDLE, !stat.timer_on, "timer running while idle")
	`TES_ASSERT(a_push_excl, clk, arst_n, !(cmd.push && (cmd.pop || cmd.halt)), "push combined with pop or halt")
	`TES_ASSERT_IMPLY(a_cmd_needs_accept, clk, arst_n, cmd.push || cmd.halt || cmd.tick, cmd.accept, "command without transaction")

endmodule

// ===== rtl/tes_datapath.sv =====
// Sequencer datapath: event queue memory with registered head read,
// pointers, owner, timer and tone generator state. Uses tes_pkg.
`include "assert_macros.svh"

module tes_datapath #(
	parameter int QUEUE_DEPTH = 32,
	parameter int MAX_TICKS   = 1000
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tes_pkg::tes_cmd_t            cmd,
	input  logic [tes_pkg::REQ_W-1:0]    requester_id,
	input  logic [tes_pkg::DIV_W-1:0]    tone_divisor,
	input  logic [tes_pkg::DUR_W-1:0]    duration_ticks,
	input  logic                         tone_flag,
	input  logic                         stop_flag,
	output tes_pkg::tes_stat_t           stat,
	output logic [tes_pkg::STATUS_W-1:0] status,
	output logic                         gate_on,
	output logic [tes_pkg::DIV_W-1:0]    divisor_out,
	output logic                         divisor_load,
	output logic [tes_pkg::LEVEL_W-1:0]  queue_level
);
	import tes_pkg::*;

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int DW = $clog2(MAX_TICKS + 1);
	localparam int EW = DIV_W + DW + 2;

	logic [EW-1:0]    mem [QUEUE_DEPTH];
	logic [EW-1:0]    head_q;
	logic [EW-1:0]    wdata;
	logic [IW-1:0]    wr_q, rd_q, rd_d;
	logic [CW-1:0]    fill_q;
	logic [REQ_W-1:0] owner_q;
	logic             gate_q;
	logic [DIV_W-1:0] loaded_q;
	logic [DW-1:0]    ticks_q;
	logic             timer_q;
	status_t          status_q;
	logic             strobe_q;
	logic [DUR_W-1:0] dur_c;
	logic [DIV_W-1:0] head_div;
	logic [DW-1:0]    head_dur;
	logic             head_tone;
	logic             sound;

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
		return (i == IW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	always_comb begin
		if (duration_ticks == '0) begin
			dur_c = DUR_W'(1);
		end else if (duration_ticks > DUR_W'(MAX_TICKS)) begin
			dur_c = DUR_W'(MAX_TICKS);
		end else begin
			dur_c = duration_ticks;
		end
	end

	assign wdata     = {tone_divisor, DW'(dur_c), stop_flag, tone_flag};
	assign head_div  = head_q[EW-1 -: DIV_W];
	assign head_dur  = head_q[DW+1:2];
	assign head_tone = head_q[0];
	assign sound     = head_tone && (head_div != '0);

	always_comb begin
		if (cmd.halt) begin
			rd_d = '0;
		end else if (cmd.pop) begin
			rd_d = next_slot(rd_q);
		end else begin
			rd_d = rd_q;
		end
	end

	// head_q always mirrors the entry at the read pointer; a write to that
	// entry in the same cycle is forwarded
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_q] <= wdata;
		end
		if (cmd.push && (wr_q == rd_d)) begin
			head_q <= wdata;
		end else begin
			head_q <= mem[rd_d];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			rd_q     <= '0;
			fill_q   <= '0;
			owner_q  <= '0;
			gate_q   <= 1'b0;
			loaded_q <= '0;
			ticks_q  <= '0;
			timer_q  <= 1'b0;
			status_q <= STAT_OK;
			strobe_q <= 1'b0;
		end else begin
			rd_q <= rd_d;
			if (cmd.accept) begin
				status_q <= cmd.status;
				strobe_q <= cmd.play && sound && (head_div != loaded_q);
			end
			if (cmd.halt) begin
				wr_q     <= '0;
				fill_q   <= '0;
				owner_q  <= '0;
				gate_q   <= 1'b0;
				loaded_q <= '0;
				ticks_q  <= '0;
				timer_q  <= 1'b0;
			end else begin
				if (cmd.push) begin
					wr_q   <= next_slot(wr_q);
					fill_q <= fill_q + 1'b1;
				end else if (cmd.pop) begin
					fill_q <= fill_q - 1'b1;
				end
				if (cmd.claim) begin
					owner_q <= requester_id;
				end
				if (cmd.play) begin
					gate_q <= sound;
					if (sound && (head_div != loaded_q)) begin
						loaded_q <= head_div;
					end
				end
				if (cmd.play && (!timer_q || cmd.timer_off)) begin
					ticks_q <= head_dur;
					timer_q <= 1'b1;
				end else if (cmd.tick) begin
					if (ticks_q != '0) begin
						ticks_q <= ticks_q - 1'b1;
					end
					if (cmd.timer_off) begin
						timer_q <= 1'b0;
					end
				end
			end
		end
	end

	assign stat.full        = (fill_q >= CW'(QUEUE_DEPTH));
	assign stat.empty       = (fill_q == '0);
	assign stat.owner_match = (owner_q == requester_id);
	assign stat.timer_on    = timer_q;
	assign stat.tick_last   = (ticks_q == '0) || (ticks_q == DW'(1));
	assign stat.head_stop   = head_q[1];

	assign status       = status_q;
	assign gate_on      = gate_q;
	assign divisor_out  = loaded_q;
	assign divisor_load = strobe_q;
	assign queue_level  = LEVEL_W'(fill_q);

	`TES_ASSERT(a_fill_bound, clk, arst_n, fill_q <= CW'(QUEUE_DEPTH), "queue fill count beyond depth")
	`TES_ASSERT_IMPLY(a_strobe_gate, clk, arst_n, strobe_q, gate_q && (loaded_q != '0), "divisor strobe without open gate")
	`TES_ASSERT_IMPLY(a_gate_loaded, clk, arst_n, gate_q, loaded_q != '0, "gate open with no divisor loaded")

endmodule

// ===== rtl/tone_event_sequencer.sv =====
// Tone event sequencer top level: joins controller and datapath to the
// item and result channels. Uses tes_pkg, tes_item_if, tes_result_if.
//
// Usage: every transaction on item carries an action (push, start, stop,
// owner exit, timer tick) with the event fields; each one yields exactly one
// transaction on result with the push status and the tone generator state
// after the item (gate, divisor, reload strobe, playing, queue level).
// The result is registered at the edge that accepts the item and is offered
// from the next cycle. Throughput is one item per cycle while the receiver
// keeps up; the head event of the queue memory is kept in a registered read
// port, so loading the next event does not wait on a memory read.
// item.ready is high whenever the result register is empty or is being taken
// in the same cycle; while the receiver stalls, the result and all state hold
// and item.ready stays low.
// Reset clears pointers, fill count, owner, timer and tone state; the queue
// memory itself is not cleared and needs no clearing pass. QUEUE_DEPTH sets
// the queue size, MAX_TICKS the duration clamp and timer width.
module tone_event_sequencer #(
	parameter int QUEUE_DEPTH = 32,
	parameter int MAX_TICKS   = 1000
) (
	input logic           clk,
	input logic           arst_n,
	tes_item_if.sink      item,
	tes_result_if.source  result
);
	import tes_pkg::*;

	tes_cmd_t  cmd;
	tes_stat_t stat;

	tes_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.action    (item.action),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd),
		.playing   (result.playing)
	);

	tes_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_TICKS   (MAX_TICKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.requester_id   (item.requester_id),
		.tone_divisor   (item.tone_divisor),
		.duration_ticks (item.duration_ticks),
		.tone_flag      (item.tone_flag),
		.stop_flag      (item.stop_flag),
		.stat           (stat),
		.status         (result.status),
		.gate_on        (result.gate_on),
		.divisor_out    (result.divisor_out),
		.divisor_load   (result.divisor_load),
		.queue_level    (result.queue_level)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for tone_event_sequencer: random and directed transactions,
// predicted results checked field by field. Depends on tes_pkg, tes_item_if,
// tes_result_if and the sequencer RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tes_pkg::*;

	localparam int DEPTH          = 32;
	localparam int MAX_TICKS      = 1000;
	localparam int TICK_W         = 10;
	localparam int REQ_MAX        = (1 << REQ_W) - 1;
	localparam int DIV_MAX        = (1 << DIV_W) - 1;
	localparam int DUR_MAX        = (1 << DUR_W) - 1;
	localparam int ACT_CODE_MAX   = (1 << ACTION_W) - 1;
	localparam int PHASE_ITEMS    = 460;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PRINT_LIMIT    = 40;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [REQ_W-1:0]    requester_id;
		logic [DIV_W-1:0]    tone_divisor;
		logic [DUR_W-1:0]    duration_ticks;
		logic                tone_flag;
		logic                stop_flag;
	} seq_item_t;

	typedef struct {
		status_t            status;
		logic               gate_on;
		logic [DIV_W-1:0]   divisor_out;
		logic               divisor_load;
		logic               playing;
		logic [LEVEL_W-1:0] queue_level;
	} seq_result_t;

	logic clk;
	logic arst_n;

	tes_item_if   item_ch();
	tes_result_if result_ch();

	tone_event_sequencer #(
		.QUEUE_DEPTH(DEPTH),
		.MAX_TICKS  (MAX_TICKS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	seq_item_t   pending_items[$];
	seq_result_t expected_results[$];
	idle_mode_t  idle_mode = IDLE_NONE;
	int          items_queued = 0;
	int          accepted_count = 0;
	int          error_count = 0;
	bit          item_taken = 0;

	// Predictor state
	logic [DIV_W-1:0]  ev_divisor [DEPTH];
	logic [TICK_W-1:0] ev_duration[DEPTH];
	logic              ev_tone    [DEPTH];
	logic              ev_stop    [DEPTH];
	int                wr_ptr, rd_ptr, events_held;
	bit                seq_active, seq_gate, seq_timing, seq_strobe;
	logic [REQ_W-1:0]  seq_owner;
	logic [DIV_W-1:0]  seq_divisor;
	int                ticks_remaining;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void silence();
		seq_timing      = 0;
		ticks_remaining = 0;
		wr_ptr          = 0;
		rd_ptr          = 0;
		events_held     = 0;
		seq_active      = 0;
		seq_owner       = '0;
		seq_gate        = 0;
		seq_divisor     = '0;
	endfunction

	function automatic void load_next_event();
		int slot;
		if (events_held == 0) begin
			silence();
			return;
		end
		slot = rd_ptr;
		rd_ptr = (rd_ptr + 1) % DEPTH;
		events_held--;
		if (ev_stop[slot]) begin
			silence();
			return;
		end
		if (ev_tone[slot] && ev_divisor[slot] != '0) begin
			// generator reloaded only on a change of divisor
			if (ev_divisor[slot] != seq_divisor) begin
				seq_divisor = ev_divisor[slot];
				seq_strobe  = 1;
			end
			seq_gate = 1;
		end else begin
			seq_gate = 0;
		end
		if (!seq_timing) begin
			ticks_remaining = ev_duration[slot];
			seq_timing      = 1;
		end
	endfunction

	function automatic seq_result_t predict_sequencer(seq_item_t it);
		seq_result_t r;
		status_t     st;
		int          dur;
		st = STAT_OK;
		seq_strobe = 0;
		case (it.action)
			ACT_PUSH: begin
				if (seq_active && seq_owner != it.requester_id) begin
					st = STAT_BUSY;
				end else if (events_held >= DEPTH) begin
					st = STAT_FULL;
				end else begin
					dur = it.duration_ticks;
					if (dur == 0)
						dur = 1;
					else if (dur > MAX_TICKS)
						dur = MAX_TICKS;
					ev_divisor[wr_ptr]  = it.tone_divisor;
					ev_duration[wr_ptr] = TICK_W'(dur);
					ev_tone[wr_ptr]     = it.tone_flag;
					ev_stop[wr_ptr]     = it.stop_flag;
					wr_ptr = (wr_ptr + 1) % DEPTH;
					events_held++;
				end
			end
			ACT_START: begin
				if (!seq_active) begin
					seq_active = 1;
					seq_owner  = it.requester_id;
					load_next_event();
				end
			end
			ACT_STOP: silence();
			ACT_EXIT: begin
				if (seq_owner == it.requester_id)
					silence();
			end
			ACT_TICK: begin
				if (seq_timing) begin
					if (ticks_remaining > 0)
						ticks_remaining--;
					if (ticks_remaining == 0) begin
						seq_timing = 0;
						if (seq_active)
							load_next_event();
					end
				end
			end
			default: ;
		endcase
		r.status       = st;
		r.gate_on      = seq_gate;
		r.divisor_out  = seq_divisor;
		r.divisor_load = seq_strobe;
		r.playing      = seq_active;
		r.queue_level  = LEVEL_W'(events_held);
		return r;
	endfunction

	task automatic report_error(string msg);
		if (error_count < PRINT_LIMIT)
			$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic void add_item(logic [ACTION_W-1:0] act, int req, int div, int dur,
			bit tone, bit stp);
		seq_item_t it;
		it.action         = act;
		it.requester_id   = REQ_W'(req);
		it.tone_divisor   = DIV_W'(div);
		it.duration_ticks = DUR_W'(dur);
		it.tone_flag      = tone;
		it.stop_flag      = stp;
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic void add_noise();
		add_item(ACTION_W'($urandom_range(0, ACT_CODE_MAX)), $urandom_range(0, REQ_MAX),
			$urandom_range(0, DIV_MAX), $urandom_range(0, DUR_MAX),
			$urandom_range(0, 1), $urandom_range(0, 1));
	endfunction

	function automatic void add_event(int req);
		int div, dur, pick;
		pick = $urandom_range(0, 99);
		// a small palette of divisors so that repeats (no reload) are common
		if (pick < 35) begin
			case ($urandom_range(0, 3))
				0: div = 0;
				1: div = DIV_MAX;
				2: div = 1193;
				default: div = 440;
			endcase
		end else begin
			div = $urandom_range(0, DIV_MAX);
		end
		pick = $urandom_range(0, 99);
		if (pick < 70)
			dur = $urandom_range(1, 3);
		else if (pick < 90)
			dur = 0;
		else
			dur = $urandom_range(0, DUR_MAX);
		add_item(ACT_PUSH, req, div, dur, chance(80), chance(6));
	endfunction

	// Well-formed playback: optional flush, fill, start, then ticks mixed with
	// interference from other requesters, then an optional ending.
	function automatic int add_phrase();
		int owner, other, n, steps, base;
		base = items_queued;
		owner = $urandom_range(0, REQ_MAX);
		if (chance(25))
			add_item(ACT_STOP, $urandom_range(0, REQ_MAX), 0, 0, 0, 0);
		n = chance(15) ? $urandom_range(30, 36) : $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			add_event(owner);
		add_item(ACT_START, owner, $urandom_range(0, DIV_MAX), 0, 0, 0);
		steps = $urandom_range(4, 30);
		for (int i = 0; i < steps; i++) begin
			other = (owner + $urandom_range(1, REQ_MAX)) % (REQ_MAX + 1);
			case ($urandom_range(0, 19))
				0, 1:    add_event(owner);
				2, 3:    add_event(other);
				4:       add_item(ACT_EXIT, other, 0, 0, 0, 0);
				5:       add_item(ACT_START, other, 0, 0, 0, 0);
				6:       add_noise();
				default: add_item(ACT_TICK, $urandom_range(0, REQ_MAX), 0, 0, 0, 0);
			endcase
		end
		case ($urandom_range(0, 3))
			0, 1:    add_item(ACT_STOP, $urandom_range(0, REQ_MAX), 0, 0, 0, 0);
			2:       add_item(ACT_EXIT, owner, 0, 0, 0, 0);
			default: ;
		endcase
		return items_queued - base;
	endfunction

	function automatic void add_directed();
		// idle: exit by requester 0 matches the cleared owner, tick with no timer
		add_item(ACT_EXIT, 0, 0, 0, 0, 0);
		add_item(ACT_TICK, REQ_MAX, DIV_MAX, DUR_MAX, 1, 1);
		for (int c = ACT_TICK + 1; c <= ACT_CODE_MAX; c++)
			add_item(ACTION_W'(c), REQ_MAX, DIV_MAX, DUR_MAX, 1, 1);
		// zero duration clamps to one; same divisor twice, rest by zero divisor,
		// rest by tone flag clear, then a stop event
		add_item(ACT_PUSH, REQ_MAX, DIV_MAX, 0, 1, 0);
		add_item(ACT_PUSH, REQ_MAX, DIV_MAX, 2, 1, 0);
		add_item(ACT_PUSH, REQ_MAX, 0, 1, 1, 0);
		add_item(ACT_PUSH, REQ_MAX, 1234, 1, 0, 0);
		add_item(ACT_PUSH, REQ_MAX, 1, 1, 1, 0);
		add_item(ACT_PUSH, REQ_MAX, 5, 1, 1, 1);
		add_item(ACT_START, REQ_MAX, 0, 0, 0, 0);
		add_item(ACT_PUSH, 0, 77, 5, 1, 0);
		add_item(ACT_START, 0, 0, 0, 0, 0);
		add_item(ACT_EXIT, 0, 0, 0, 0, 0);
		for (int i = 0; i < 6; i++)
			add_item(ACT_TICK, 0, 0, 0, 0, 0);
		// start on an empty queue stops at once
		add_item(ACT_START, 5, 0, 0, 0, 0);
		// long durations clamp to the ceiling; owner exit ends playback
		add_item(ACT_PUSH, 0, 16'h00FF, DUR_MAX, 1, 0);
		add_item(ACT_PUSH, 0, 16'h0100, MAX_TICKS, 1, 0);
		add_item(ACT_START, 0, 0, 0, 0, 0);
		add_item(ACT_TICK, 0, 0, 0, 0, 0);
		add_item(ACT_EXIT, 0, 0, 0, 0, 0);
	endfunction

	// Driver: new transaction offered at the falling edge once the last one is taken
	always @(negedge clk) begin : driver
		seq_item_t it;
		bit        hold_off;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || item_taken) begin
			hold_off = (idle_mode == IDLE_SEND && chance(78)) ||
				(idle_mode == IDLE_BOTH && chance(17));
			if (pending_items.size() != 0 && !hold_off) begin
				it = pending_items.pop_front();
				item_ch.action         <= it.action;
				item_ch.requester_id   <= it.requester_id;
				item_ch.tone_divisor   <= it.tone_divisor;
				item_ch.duration_ticks <= it.duration_ticks;
				item_ch.tone_flag      <= it.tone_flag;
				item_ch.stop_flag      <= it.stop_flag;
				item_ch.valid          <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
		case (idle_mode)
			IDLE_RECV: result_ch.ready <= !chance(78);
			IDLE_BOTH: result_ch.ready <= !chance(17);
			default:   result_ch.ready <= 1'b1;
		endcase
	end

	// Monitor: checks results against the oldest prediction, predicts new ones
	always @(posedge clk) begin : monitor
		seq_item_t   it;
		seq_result_t want;
		item_taken = arst_n && item_ch.valid && item_ch.ready;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				report_error("result transaction with no prediction waiting");
			end else begin
				want = expected_results.pop_front();
				check_field("status", result_ch.status, want.status);
				check_field("gate_on", result_ch.gate_on, want.gate_on);
				check_field("divisor_out", result_ch.divisor_out, want.divisor_out);
				check_field("divisor_load", result_ch.divisor_load, want.divisor_load);
				check_field("playing", result_ch.playing, want.playing);
				check_field("queue_level", result_ch.queue_level, want.queue_level);
			end
		end
		if (item_taken) begin
			it.action         = item_ch.action;
			it.requester_id   = item_ch.requester_id;
			it.tone_divisor   = item_ch.tone_divisor;
			it.duration_ticks = item_ch.duration_ticks;
			it.tone_flag      = item_ch.tone_flag;
			it.stop_flag      = item_ch.stop_flag;
			expected_results.push_back(predict_sequencer(it));
			accepted_count++;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (arst_n && !(item_ch.valid && item_ch.ready) &&
					!(result_ch.valid && result_ch.ready))
				quiet++;
			else
				quiet = 0;
		end
		$display("** tone_event_sequencer: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int phase_count;
		arst_n                 = 1'b0;
		item_ch.valid          = 1'b0;
		item_ch.action         = ACT_PUSH;
		item_ch.requester_id   = '0;
		item_ch.tone_divisor   = '0;
		item_ch.duration_ticks = '0;
		item_ch.tone_flag      = 1'b0;
		item_ch.stop_flag      = 1'b0;
		result_ch.ready        = 1'b0;
		silence();
		seq_strobe = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		for (int p = IDLE_NONE; p <= IDLE_BOTH; p++) begin
			idle_mode = idle_mode_t'(p);
			if (p == IDLE_NONE)
				add_directed();
			phase_count = 0;
			while (phase_count < PHASE_ITEMS) begin
				if (chance(85)) begin
					phase_count += add_phrase();
				end else begin
					repeat ($urandom_range(1, 5))
						add_noise();
				end
			end
			// sender holds off until every prediction has been matched
			while (accepted_count != items_queued || expected_results.size() != 0)
				@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (error_count == 0 && expected_results.size() == 0)
			$display("** tone_event_sequencer: PASSED **");
		else
			$display("** tone_event_sequencer: FAILED **");
		$finish;
	end

endmodule
